[rtl/sks_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sks_pkg - shared definitions for the symmetric kernel smoother
// Field widths, register indexes and the control bundle of the MAC unit.
// ----------------------------------------------------------------------------
package sks_pkg;

    localparam int MAX_RADIUS_DEF = 6;   // default largest kernel radius
    localparam int CFG_TAPS       = 7;   // taps reachable through the register map
    localparam int SAMPLE_W       = 16;
    localparam int TAP_W          = 16;
    localparam int RADIUS_W       = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP0   = 3'd1;

    typedef struct packed {
        logic clear;   // empty the accumulators
        logic en;      // take one sample and weight this cycle
    } t_mac_ctl;

endpackage

[rtl/symmetric_kernel_smoother.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_kernel_smoother - normalised symmetric kernel smoothing
// Weighted window average of a sample stream, window clipped at vector ends.
// ----------------------------------------------------------------------------
// Samples enter on the s_axis channel (tdata = sample, tlast = last of the
// vector); smoothed values leave on m_axis (tdata = value, tuser = zero
// weight flag, tlast = last output of the vector). The user must set radius and
// taps through the write port only while the block is idle; the block itself
// does not enforce this. Each input beat shifts into a 2*MAX_RADIUS+1 deep
// window. An output is due once radius samples lie beyond its centre; tlast
// flushes all outstanding outputs and empties the window.
// Every output takes a pass over all 2*MAX_RADIUS+1 window positions in the
// shared multiply-accumulate unit, the drain and divide-start states, then
// the serial divider, and finally a load of the output register. A zero
// weight sum skips the divider. A beat that yields no output leaves s_axis
// ready for the next beat.
// s_axis tready is low while outputs are being worked on. If m_axis stalls,
// the next result waits in the sequencer until the output register empties.
// Reset clears the window, the pending count, radius (0) and taps (tap 0 at
// 65535, the rest 0).
// ----------------------------------------------------------------------------
module symmetric_kernel_smoother import sks_pkg::*; #(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [15:0]           i_s_axis_tdata,   // [15:0] sample
    input  logic                  i_s_axis_tlast,   // final_sample
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [15:0]           o_m_axis_tdata,   // [15:0] smoothed
    output logic                  o_m_axis_tuser,   // [0] zero_weight
    output logic                  o_m_axis_tlast,   // end_of_vector
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int WD = 2 * MAX_RADIUS + 1;
    localparam int NT = MAX_RADIUS + 1;
    localparam int JW = $clog2(WD);
    localparam int TW = $clog2(NT);
    localparam int RW = $clog2(MAX_RADIUS + 1);
    localparam int PW = $clog2(MAX_RADIUS + 2);
    localparam int AW = 32 + $clog2(WD);
    localparam int SW = 16 + $clog2(WD);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_DIVS = 3'd3;
    localparam logic [2:0] S_DIVW = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]                r_state;
    logic [RADIUS_W-1:0]       r_radius;
    logic [TAP_W-1:0]          r_taps [NT];
    logic signed [SAMPLE_W-1:0] r_win [WD];
    logic [WD-1:0]             r_wvalid;
    logic [PW-1:0]             r_fill;
    logic [PW-1:0]             r_pend;
    logic                      r_final;
    logic [JW-1:0]             r_j;
    logic                      r_zero;
    logic                      r_neg;
    logic                      r_m_valid;
    logic [15:0]               r_m_data;
    logic                      r_m_zero;
    logic                      r_m_last;

    logic [RW-1:0]             eff_r;
    logic                      s_acc;
    logic [PW-1:0]             n_pend;
    logic [PW-1:0]             target_in;
    logic [PW-1:0]             target_run;
    logic [JW-1:0]             centre;
    logic [JW-1:0]             tap_dist;
    logic                      in_kernel;
    logic [TAP_W-1:0]          weight;
    t_mac_ctl                  mac_ctl;
    logic signed [AW-1:0]      mac_acc;
    logic [SW-1:0]             mac_wsum;
    logic [AW-1:0]             acc_mag;
    logic                      div_start;
    logic                      div_busy;
    logic                      div_done;
    logic [AW-1:0]             div_quo;
    logic [15:0]               q16;
    logic [15:0]               result;
    logic                      out_free;

    always_comb begin
        if (32'(r_radius) > MAX_RADIUS) begin
            eff_r = RW'(MAX_RADIUS);
        end else begin
            eff_r = RW'(r_radius);
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign target_in       = i_s_axis_tlast ? '0 : PW'(eff_r);
    assign target_run      = r_final ? '0 : PW'(eff_r);
    assign n_pend          = r_pend - 1'b1;

    // distance of the scanned position from the centre being smoothed
    assign centre    = JW'(n_pend);
    assign tap_dist  = (r_j >= centre) ? (r_j - centre) : (centre - r_j);
    assign in_kernel = r_wvalid[r_j] && (32'(tap_dist) <= 32'(eff_r));
    assign weight    = in_kernel ? r_taps[tap_dist[TW-1:0]] : '0;

    assign mac_ctl.clear = (r_state == S_IDLE) || (r_state == S_OUT);
    assign mac_ctl.en    = (r_state == S_SCAN);

    skm_mac #(
        .AW (AW),
        .SW (SW)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_sample (r_win[r_j]),
        .i_weight (weight),
        .o_acc    (mac_acc),
        .o_wsum   (mac_wsum)
    );

    assign acc_mag   = mac_acc[AW-1] ? AW'(-mac_acc) : AW'(mac_acc);
    assign div_start = (r_state == S_DIVS) && (mac_wsum != '0);

    skm_div #(
        .NW (AW),
        .DW (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (acc_mag),
        .i_den   (mac_wsum),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign q16      = div_quo[15:0];
    assign result   = r_zero ? 16'd0 : (r_neg ? (~q16 + 16'd1) : q16);
    assign out_free = !r_m_valid || i_m_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            for (int k = 0; k < NT; k++) begin
                r_taps[k] <= (k == 0) ? {TAP_W{1'b1}} : '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_RADIUS) begin
                r_radius <= i_cfg_wdata[RADIUS_W-1:0];
            end
            for (int k = 0; k < NT; k++) begin
                if (k < CFG_TAPS && i_cfg_idx == CFG_IDX_W'(REG_TAP0 + k)) begin
                    r_taps[k] <= i_cfg_wdata[TAP_W-1:0];
                end
            end
        end
    end

    // sample window, newest at position 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WD; k++) begin
                r_win[k] <= '0;
            end
        end else if (s_acc) begin
            r_win[0] <= $signed(i_s_axis_tdata);
            for (int k = 1; k < WD; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wvalid  <= '0;
            r_fill    <= '0;
            r_pend    <= '0;
            r_final   <= 1'b0;
            r_j       <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // the output state loads the register itself
            if (i_m_axis_tready && r_state != S_OUT) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_wvalid <= {r_wvalid[WD-2:0], 1'b1};
                        r_final  <= i_s_axis_tlast;
                        r_j      <= '0;
                        if (r_fill + 1'b1 > target_in) begin
                            r_pend  <= r_fill + 1'b1;
                            r_state <= S_SCAN;
                        end else begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    r_j <= r_j + 1'b1;
                    if (r_j == JW'(WD - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DIVS;
                end
                S_DIVS: begin
                    r_zero  <= (mac_wsum == '0);
                    r_neg   <= mac_acc[AW-1];
                    r_state <= (mac_wsum == '0) ? S_OUT : S_DIVW;
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= result;
                        r_m_zero  <= r_zero;
                        r_m_last  <= r_final && (r_pend == PW'(1));
                        r_pend    <= n_pend;
                        r_j       <= '0;
                        if (n_pend > target_run) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_fill  <= n_pend;
                            r_state <= S_IDLE;
                            if (r_final) begin
                                r_wvalid <= '0;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_zero;
    assign o_m_axis_tlast  = r_m_last;

    a_pend_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_pend != '0))
        else $error("pending count empty while working");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= MAX_RADIUS)
        else $error("pending count beyond window");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == S_DIVW))
        else $error("divider running outside its wait state");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_OUT))
        else $error("output loaded outside the output state");

endmodule

[rtl/skm_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skm_mac - shared multiply-accumulate unit
// One signed sample times one unsigned weight per cycle, product registered,
// then summed into a wide accumulator alongside the running weight sum.
// ----------------------------------------------------------------------------
module skm_mac import sks_pkg::*; #(
    parameter int AW = 36,
    parameter int SW = 20
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_ctl                   i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic        [TAP_W-1:0]    i_weight,
    output logic signed [AW-1:0]       o_acc,
    output logic        [SW-1:0]       o_wsum
);

    logic signed [SAMPLE_W+TAP_W:0] r_prod;
    logic        [TAP_W-1:0]        r_pw;
    logic                           r_pv;
    logic signed [AW-1:0]           r_acc;
    logic        [SW-1:0]           r_wsum;

    always_ff @(posedge i_clk) begin
        r_prod <= i_sample * $signed({1'b0, i_weight});
        r_pw   <= i_weight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_pv   <= 1'b0;
            r_acc  <= '0;
            r_wsum <= '0;
        end else begin
            r_pv <= i_ctl.en;
            if (r_pv) begin
                r_acc  <= r_acc + AW'(r_prod);
                r_wsum <= r_wsum + SW'(r_pw);
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_wsum = r_wsum;

endmodule

[rtl/skm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skm_div - serial unsigned divider
// Restoring division, one quotient bit per cycle, NW quotient bits per divide.
// ----------------------------------------------------------------------------
module skm_div #(
    parameter int NW = 36,
    parameter int DW = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW:0]   shifted;
    logic [DW:0]   trial;
    logic          ge;

    assign shifted = {r_rem, r_num[NW-1]};
    assign trial   = shifted - {1'b0, r_den};
    assign ge      = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            // remainder stays below the divisor, so DW bits hold it
            r_rem <= ge ? trial[DW-1:0] : shifted[DW-1:0];
            r_num <= {r_num[NW-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule
